// ===== sv/nls_pkg.sv =====
// ---------------------------------------------------------------------------
// nls_pkg
// Shared constants for the nearest label search unit: field widths,
// opcodes, register indexes and reset values.
// ---------------------------------------------------------------------------
package nls_pkg;

  // Defaults for the top-level parameters.
  localparam int GRID_SIDE_DEF  = 32;
  localparam int LABEL_BITS_DEF = 8;

  // Fixed widths of the word fields.
  localparam int OP_W       = 2;
  localparam int COORD_W    = 5;
  localparam int LABEL_W    = 8;
  localparam int RAD_W      = 5;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NB_RADIUS  = 1'd1;

  // Register reset values.
  localparam logic [LABEL_W-1:0] EMPTY_CODE_RST = 8'd0;
  localparam logic [RAD_W-1:0]   NB_RADIUS_RST  = 5'd5;

  // Counts saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

endpackage

// ===== sv/nls_in_if.sv =====
// ---------------------------------------------------------------------------
// nls_in_if
// Request channel: opcode, origin or target cell, label and window radius.
// ---------------------------------------------------------------------------
interface nls_in_if
  import nls_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [LABEL_W-1:0] label;
  logic [RAD_W-1:0]   radius;

  modport source (output valid, opcode, col, row, label, radius, input ready);
  modport sink   (input valid, opcode, col, row, label, radius, output ready);
endinterface

// ===== sv/nls_out_if.sv =====
// ---------------------------------------------------------------------------
// nls_out_if
// Result channel: found flag, matching cell and match count.
// ---------------------------------------------------------------------------
interface nls_out_if
  import nls_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] match_col;
  logic [COORD_W-1:0] match_row;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, found, match_col, match_row, match_count, input ready);
  modport sink   (input valid, found, match_col, match_row, match_count, output ready);
endinterface

// ===== sv/nls_grid_ram.sv =====
// ---------------------------------------------------------------------------
// nls_grid_ram
// Label store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module nls_grid_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/nearest_label_search_unit.sv =====
// ---------------------------------------------------------------------------
// nearest_label_search_unit
// Grid label store with nearest-match search and window match counts.
// ---------------------------------------------------------------------------
// The unit holds a GRID_SIDE x GRID_SIDE label grid in one synchronous RAM
// and works on one word at a time, reading one cell per cycle. After reset
// a clearing pass writes every cell to zero; no request is taken until it
// ends, though configuration writes are. A write goes from the idle state
// through the done state to the result register. A window count scans the
// clipped window, unless it is empty, then passes the drain, phase and done
// states. A nearest search scans the whole grid, then, if it found a hit,
// counts matches in the clipped neighborhood window around the hit. The
// single RAM read port sets the scan rate. A finished result sits in an
// output register, so a new request is taken while the previous result
// waits.
// ---------------------------------------------------------------------------
module nearest_label_search_unit
  import nls_pkg::*;
#(
  parameter int GRID_SIDE  = GRID_SIDE_DEF,
  parameter int LABEL_BITS = LABEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  nls_in_if.sink                in_ch,
  nls_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(GRID_SIDE);
  localparam int SPAN  = (GRID_SIDE > 32) ? GRID_SIDE : 32;
  localparam int SW    = $clog2(SPAN) + 1;
  localparam int MW    = (LABEL_BITS > LABEL_W) ? LABEL_BITS : LABEL_W;

  localparam logic [SW-1:0]         GMAX      = SW'(GRID_SIDE - 1);
  localparam logic [SW-1:0]         GSIDE     = SW'(GRID_SIDE);
  localparam logic [SW-1:0]         BEST_INIT = SW'(GRID_SIDE + 1);
  localparam logic [AW-1:0]         LAST_CELL = AW'(CELLS - 1);
  localparam logic [LABEL_BITS-1:0] CELL_RST  = LABEL_BITS'(EMPTY_CODE_RST);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_PHASE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Control registers.
  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic               srch_r, srch_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] empty_code_r, empty_code_nxt;
  logic [RAD_W-1:0]   nb_rad_r, nb_rad_nxt;

  // Datapath registers.
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [SW-1:0]      org_c_r, org_c_nxt, org_r_r, org_r_nxt;
  logic [SW-1:0]      sc_c_r, sc_c_nxt, sc_r_r, sc_r_nxt;
  logic [SW-1:0]      lo_c_r, lo_c_nxt, hi_c_r, hi_c_nxt, hi_r_r, hi_r_nxt;
  logic [SW-1:0]      rd_c_r, rd_c_nxt, rd_r_r, rd_r_nxt;
  logic [SW-1:0]      best_r, best_nxt, bc_r, bc_nxt, br_r, br_nxt;
  logic               found_r, found_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               o_found_r, o_found_nxt;
  logic [COORD_W-1:0] o_col_r, o_col_nxt, o_row_r, o_row_nxt;
  logic [COUNT_W-1:0] o_cnt_r, o_cnt_nxt;

  // RAM ports.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [LABEL_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [LABEL_BITS-1:0] mem_rdata;

  nls_grid_ram #(
    .DEPTH  (CELLS),
    .DATA_W (LABEL_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign mem_raddr = AW'(sc_r_r[IW-1:0]) * AW'(GRID_SIDE) + AW'(sc_c_r[IW-1:0]);

  // Cell match and Chebyshev distance for the word coming out of the RAM.
  logic [MW-1:0] cell_ext;
  logic          hit;
  logic          at_org;
  logic [SW-1:0] dx, dy, cheb_d;

  always_comb begin
    cell_ext = MW'(mem_rdata);
    hit      = (cell_ext != MW'(empty_code_r)) && (cell_ext == MW'(label_r));
    at_org   = (rd_c_r == org_c_r) && (rd_r_r == org_r_r);
    dx       = (rd_c_r > org_c_r) ? rd_c_r - org_c_r : org_c_r - rd_c_r;
    dy       = (rd_r_r > org_r_r) ? rd_r_r - org_r_r : org_r_r - rd_r_r;
    cheb_d   = (dx > dy) ? dx : dy;
  end

  // Clipped window bounds; the center is the hit during the phase change,
  // otherwise the incoming origin.
  logic [SW-1:0] wo_c, wo_r, wrad, w_sum_c, w_sum_r;
  logic [SW-1:0] w_lo_c, w_hi_c, w_lo_r, w_hi_r;
  logic          w_empty;

  always_comb begin
    if (state_r == ST_PHASE) begin
      wo_c = bc_r;
      wo_r = br_r;
      wrad = SW'(nb_rad_r);
    end else begin
      wo_c = SW'(in_ch.col);
      wo_r = SW'(in_ch.row);
      wrad = SW'(in_ch.radius);
    end
    w_sum_c = wo_c + wrad;
    w_sum_r = wo_r + wrad;
    w_lo_c  = (wo_c >= wrad) ? wo_c - wrad : '0;
    w_lo_r  = (wo_r >= wrad) ? wo_r - wrad : '0;
    w_hi_c  = (w_sum_c > GMAX) ? GMAX : w_sum_c;
    w_hi_r  = (w_sum_r > GMAX) ? GMAX : w_sum_r;
    w_empty = (w_lo_c > w_hi_c) || (w_lo_r > w_hi_r);
  end

  logic in_grid;
  assign in_grid = (SW'(in_ch.col) < GSIDE) && (SW'(in_ch.row) < GSIDE);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    rd_v_nxt       = 1'b0;
    srch_nxt       = srch_r;
    out_valid_nxt  = out_valid_r;
    empty_code_nxt = empty_code_r;
    nb_rad_nxt     = nb_rad_r;
    label_nxt      = label_r;
    org_c_nxt      = org_c_r;
    org_r_nxt      = org_r_r;
    sc_c_nxt       = sc_c_r;
    sc_r_nxt       = sc_r_r;
    lo_c_nxt       = lo_c_r;
    hi_c_nxt       = hi_c_r;
    hi_r_nxt       = hi_r_r;
    rd_c_nxt       = rd_c_r;
    rd_r_nxt       = rd_r_r;
    best_nxt       = best_r;
    bc_nxt         = bc_r;
    br_nxt         = br_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    o_found_nxt    = o_found_r;
    o_col_nxt      = o_col_r;
    o_row_nxt      = o_row_r;
    o_cnt_nxt      = o_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = CELL_RST;

    if (cfg_we) begin
      case (cfg_index)
        REG_EMPTY_CODE: empty_code_nxt = cfg_wdata;
        REG_NB_RADIUS:  nb_rad_nxt     = cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Evaluate the cell read in the previous cycle.
    if (rd_v_r && hit) begin
      if (srch_r) begin
        if (!at_org && (cheb_d < best_r)) begin
          best_nxt  = cheb_d;
          bc_nxt    = rd_c_r;
          br_nxt    = rd_r_r;
          found_nxt = 1'b1;
        end
      end else if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          label_nxt = in_ch.label;
          org_c_nxt = SW'(in_ch.col);
          org_r_nxt = SW'(in_ch.row);
          found_nxt = 1'b0;
          bc_nxt    = '0;
          br_nxt    = '0;
          cnt_nxt   = '0;
          best_nxt  = BEST_INIT;
          case (in_ch.opcode)
            OP_WRITE: begin
              mem_we    = in_grid;
              mem_waddr = AW'(in_ch.row[IW-1:0]) * AW'(GRID_SIDE)
                        + AW'(in_ch.col[IW-1:0]);
              mem_wdata = LABEL_BITS'(in_ch.label);
              state_nxt = ST_DONE;
            end
            OP_SEARCH: begin
              srch_nxt  = 1'b1;
              sc_c_nxt  = '0;
              sc_r_nxt  = '0;
              lo_c_nxt  = '0;
              hi_c_nxt  = GMAX;
              hi_r_nxt  = GMAX;
              state_nxt = ST_SCAN;
            end
            OP_COUNT: begin
              srch_nxt  = 1'b0;
              sc_c_nxt  = w_lo_c;
              sc_r_nxt  = w_lo_r;
              lo_c_nxt  = w_lo_c;
              hi_c_nxt  = w_hi_c;
              hi_r_nxt  = w_hi_r;
              state_nxt = w_empty ? ST_DONE : ST_SCAN;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        rd_v_nxt = 1'b1;
        rd_c_nxt = sc_c_r;
        rd_r_nxt = sc_r_r;
        if (sc_c_r == hi_c_r) begin
          sc_c_nxt = lo_c_r;
          sc_r_nxt = sc_r_r + 1'b1;
          if (sc_r_r == hi_r_r) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          sc_c_nxt = sc_c_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        // A finished search with a hit goes on to the neighborhood count.
        if (srch_r && found_r) begin
          srch_nxt  = 1'b0;
          sc_c_nxt  = w_lo_c;
          sc_r_nxt  = w_lo_r;
          lo_c_nxt  = w_lo_c;
          hi_c_nxt  = w_hi_c;
          hi_r_nxt  = w_hi_r;
          state_nxt = w_empty ? ST_DONE : ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = found_r;
          o_col_nxt     = COORD_W'(bc_r);
          o_row_nxt     = COORD_W'(br_r);
          o_cnt_nxt     = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      rd_v_r       <= 1'b0;
      srch_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      empty_code_r <= EMPTY_CODE_RST;
      nb_rad_r     <= NB_RADIUS_RST;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      rd_v_r       <= rd_v_nxt;
      srch_r       <= srch_nxt;
      out_valid_r  <= out_valid_nxt;
      empty_code_r <= empty_code_nxt;
      nb_rad_r     <= nb_rad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    label_r   <= label_nxt;
    org_c_r   <= org_c_nxt;
    org_r_r   <= org_r_nxt;
    sc_c_r    <= sc_c_nxt;
    sc_r_r    <= sc_r_nxt;
    lo_c_r    <= lo_c_nxt;
    hi_c_r    <= hi_c_nxt;
    hi_r_r    <= hi_r_nxt;
    rd_c_r    <= rd_c_nxt;
    rd_r_r    <= rd_r_nxt;
    best_r    <= best_nxt;
    bc_r      <= bc_nxt;
    br_r      <= br_nxt;
    found_r   <= found_nxt;
    cnt_r     <= cnt_nxt;
    o_found_r <= o_found_nxt;
    o_col_r   <= o_col_nxt;
    o_row_r   <= o_row_nxt;
    o_cnt_r   <= o_cnt_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = o_found_r;
  assign out_ch.match_col   = o_col_r;
  assign out_ch.match_row   = o_row_r;
  assign out_ch.match_count = o_cnt_r;

  // The hit cell always lies in its own neighborhood window.
  a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> out_ch.match_count != '0)
    else $error("found result with zero count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.match_col == '0 && out_ch.match_row == '0)
    else $error("miss result carries a position");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> state_r == ST_SCAN || state_r == ST_DRAIN)
    else $error("read data evaluated outside a scan");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second word taken while one is in progress");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_label_search_unit. A clocked driver offers
// request words from a queue, a clocked monitor takes result words and
// compares them field by field with what a grid model predicts for each
// accepted request. Phases change the two registers and the amount of idling
// on both channels, and one phase holds the result channel off for a long
// stretch so that the unit backs up into its request channel.
// ---------------------------------------------------------------------------
module tb;
  import nls_pkg::*;

  localparam int SIDE        = GRID_SIDE_DEF;
  localparam int HOLD_CYCLES = 3000;
  localparam int QUIET_LIMIT = 25000;
  localparam int RANDOM_ITEMS_PER_PHASE = 100;

  // The unit returns all zeros for the one opcode it does not use.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LABEL_W-1:0] label;
    logic [RAD_W-1:0]   radius;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] match_col;
    logic [COORD_W-1:0] match_row;
    logic [COUNT_W-1:0] match_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nls_in_if  in_ch ();
  nls_out_if out_ch ();

  nearest_label_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Grid model and its two registers.
  logic [LABEL_W-1:0] grid_model [0:SIDE*SIDE-1];
  logic [LABEL_W-1:0] empty_label;
  logic [RAD_W-1:0]   nb_radius;

  request_t pending_reqs [$];
  answer_t  expected_answers [$];

  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches;
  int   quiet_cycles;
  logic pressure_go;
  logic hold_off;

  function automatic bit cell_matches(int c, int r, logic [LABEL_W-1:0] label);
    logic [LABEL_W-1:0] v;
    if (c < 0 || r < 0 || c >= SIDE || r >= SIDE) return 1'b0;
    v = grid_model[r*SIDE + c];
    return (v != empty_label) && (v == label);
  endfunction

  // Matching cells in a square window, clipped at every edge of the grid.
  function automatic int count_in_window(int oc, int orow, int rad,
                                         logic [LABEL_W-1:0] label);
    int r0, r1, c0, c1, n;
    r0 = (orow - rad < 0) ? 0 : orow - rad;
    c0 = (oc - rad < 0) ? 0 : oc - rad;
    r1 = (orow + rad > SIDE - 1) ? SIDE - 1 : orow + rad;
    c1 = (oc + rad > SIDE - 1) ? SIDE - 1 : oc + rad;
    n = 0;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        if (cell_matches(c, r, label) && n < COUNT_MAX) n++;
    return n;
  endfunction

  // Works out the answer to one accepted request and applies any write.
  function automatic answer_t predict_answer(request_t rq);
    answer_t ans;
    int best, bc, br, d, dx, dy, oc, orow, n;
    ans = '0;
    oc = rq.col;
    orow = rq.row;
    case (rq.opcode)
      OP_WRITE: begin
        grid_model[orow*SIDE + oc] = rq.label;
      end
      OP_SEARCH: begin
        best = SIDE + 1;
        bc = 0;
        br = 0;
        // Strict less-than keeps the first cell in raster order on a tie.
        for (int r = 0; r < SIDE; r++)
          for (int c = 0; c < SIDE; c++) begin
            if (!(r == orow && c == oc) && cell_matches(c, r, rq.label)) begin
              dx = (c > oc) ? c - oc : oc - c;
              dy = (r > orow) ? r - orow : orow - r;
              d = (dx > dy) ? dx : dy;
              if (d < best) begin
                best = d;
                bc = c;
                br = r;
              end
            end
          end
        if (best <= SIDE) begin
          n = count_in_window(bc, br, nb_radius, rq.label);
          ans.found = 1'b1;
          ans.match_col = bc[COORD_W-1:0];
          ans.match_row = br[COORD_W-1:0];
          ans.match_count = n[COUNT_W-1:0];
        end
      end
      OP_COUNT: begin
        n = count_in_window(oc, orow, rq.radius, rq.label);
        ans.match_count = n[COUNT_W-1:0];
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Request driver.
  always @(posedge clk) begin : driver
    request_t taken;
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.opcode = in_ch.opcode;
        taken.col    = in_ch.col;
        taken.row    = in_ch.row;
        taken.label  = in_ch.label;
        taken.radius = in_ch.radius;
        expected_answers.push_back(predict_answer(taken));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.opcode <= nxt.opcode;
          in_ch.col    <= nxt.col;
          in_ch.row    <= nxt.row;
          in_ch.label  <= nxt.label;
          in_ch.radius <= nxt.radius;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result word arrived with no request waiting");
        end else begin
          want = expected_answers.pop_front();
          check_field("found", 16'(out_ch.found), 16'(want.found));
          check_field("match_col", 16'(out_ch.match_col), 16'(want.match_col));
          check_field("match_row", 16'(out_ch.match_row), 16'(want.match_row));
          check_field("match_count", 16'(out_ch.match_count), 16'(want.match_count));
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, so the unit fills and stalls its request side.
  initial begin : hold_off_ctl
    hold_off = 1'b0;
    wait (pressure_go === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(99) < 15) return $urandom_range(1) ? 5'd31 : 5'd0;
    return COORD_W'($urandom_range(SIDE - 1));
  endfunction

  // Mostly a few labels, so that searches and counts find company.
  function automatic logic [LABEL_W-1:0] pick_label();
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(4))
        0: return 8'd0;
        1: return 8'd1;
        2: return 8'd2;
        3: return 8'd3;
        default: return 8'd255;
      endcase
    end
    return LABEL_W'($urandom_range(255));
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)      rq.opcode = OP_WRITE;
    else if (roll < 65) rq.opcode = OP_COUNT;
    else if (roll < 85) rq.opcode = OP_SEARCH;
    else if (roll < 90) rq.opcode = OP_UNUSED;
    else                rq.opcode = OP_W'($urandom_range(3));
    rq.col = pick_coord();
    rq.row = pick_coord();
    rq.label = pick_label();
    rq.radius = ($urandom_range(9) == 0) ? RAD_W'($urandom_range(31))
                                         : RAD_W'($urandom_range(3));
    return rq;
  endfunction

  function automatic request_t make_request(logic [OP_W-1:0] op, int c, int r,
                                            int label, int rad);
    request_t rq;
    rq.opcode = op;
    rq.col = COORD_W'(c);
    rq.row = COORD_W'(r);
    rq.label = LABEL_W'(label);
    rq.radius = RAD_W'(rad);
    return rq;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EMPTY_CODE) empty_label = data;
    else if (idx == REG_NB_RADIUS) nb_radius = data[RAD_W-1:0];
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] empty, logic [CFG_DATA_W-1:0] rad);
    write_reg(REG_EMPTY_CODE, empty);
    write_reg(REG_NB_RADIUS, rad);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_ch.valid !== 1'b0 ||
           expected_answers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int n, int send_pct, int recv_pct, bit with_hold);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    if (with_hold) pressure_go <= 1'b1;
    @(posedge clk);
    repeat (n) pending_reqs.push_back(random_request());
    wait_idle();
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.col = '0;
    in_ch.row = '0;
    in_ch.label = '0;
    in_ch.radius = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    pressure_go = 1'b0;
    empty_label = EMPTY_CODE_RST;
    nb_radius = NB_RADIUS_RST;
    for (int i = 0; i < SIDE*SIDE; i++) grid_model[i] = EMPTY_CODE_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    pending_reqs.push_back(make_request(OP_SEARCH, 5, 5, 1, 0));    // empty grid
    pending_reqs.push_back(make_request(OP_COUNT, 0, 0, 0, 31));    // label is empty code
    pending_reqs.push_back(make_request(OP_UNUSED, 31, 31, 255, 31));
    pending_reqs.push_back(make_request(OP_WRITE, 0, 0, 1, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 31, 31, 1, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 31, 0, 1, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 0, 31, 255, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 16, 16, 1, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 17, 15, 1, 0));
    pending_reqs.push_back(make_request(OP_WRITE, 0, 1, 1, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 0, 0, 1, 0));    // origin skipped
    pending_reqs.push_back(make_request(OP_SEARCH, 16, 16, 1, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 31, 31, 255, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 31, 31, 1, 0));
    pending_reqs.push_back(make_request(OP_COUNT, 16, 16, 1, 31));
    pending_reqs.push_back(make_request(OP_COUNT, 31, 31, 1, 0));   // origin counted
    pending_reqs.push_back(make_request(OP_COUNT, 31, 0, 1, 1));
    pending_reqs.push_back(make_request(OP_WRITE, 0, 1, 0, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 0, 0, 1, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 10, 10, 200, 0)); // no match anywhere
    pending_reqs.push_back(make_request(OP_UNUSED, 0, 0, 0, 0));
    wait_idle();

    // A used label becomes the empty code; old zero cells now match label 0.
    set_regs(8'd1, 8'd0);
    pending_reqs.push_back(make_request(OP_SEARCH, 20, 20, 1, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 0, 0, 255, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 6, 6, 0, 0));
    pending_reqs.push_back(make_request(OP_COUNT, 16, 16, 0, 31));
    wait_idle();

    set_regs(8'd255, 8'd31);
    pending_reqs.push_back(make_request(OP_SEARCH, 31, 31, 255, 0));
    pending_reqs.push_back(make_request(OP_SEARCH, 15, 15, 0, 0));
    wait_idle();

    // Random phases with different register settings and idling.
    set_regs(8'd0, 8'd5);
    run_random(RANDOM_ITEMS_PER_PHASE, 0, 0, 1'b0);
    set_regs(pick_label(), 8'd31);
    run_random(RANDOM_ITEMS_PER_PHASE, 65, 0, 1'b0);
    set_regs(pick_label(), CFG_DATA_W'($urandom_range(31)));
    run_random(RANDOM_ITEMS_PER_PHASE, 0, 65, 1'b0);
    set_regs(8'd255, 8'd0);
    run_random(RANDOM_ITEMS_PER_PHASE, 18, 18, 1'b0);
    set_regs(8'd0, CFG_DATA_W'($urandom_range(7)));
    run_random(RANDOM_ITEMS_PER_PHASE, 0, 0, 1'b1);

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nls_pkg.sv
sv/nls_in_if.sv
sv/nls_out_if.sv
sv/nls_grid_ram.sv
sv/nearest_label_search_unit.sv
test/tb.sv
